### hw/rtl/stst_pkg.sv
// Shared constants and types for the texture slot table.
// No dependencies; the other files in hw/rtl, except stst_slot_mem, refer to this package by scoped name.
package stst_pkg;

    localparam int unsigned SLOTS_DEFAULT    = 16;
    localparam int unsigned MODELS_DEFAULT   = 16;
    localparam int unsigned TAG_BITS_DEFAULT = 64;

    // Fixed port field widths
    localparam int unsigned TAG_W       = 64;
    localparam int unsigned MODEL_W     = 4;
    localparam int unsigned IDX_OUT_W   = 4;
    localparam int unsigned COUNT_OUT_W = 5;

    localparam logic CMD_BIND    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Update request to the valid-bit tracker
    typedef struct packed {
        logic set_en;
        logic clr_en;
    } stst_vop_t;

endpackage

### hw/rtl/shared_texture_slot_table_unit.sv
// Shared texture slot table: tag lookup, slot claim and per-model release.
// Depends on stst_pkg, stst_slot_mem and stst_valid_bits.
//
// Usage:
//   Command channel: an item is taken on a rising edge with start high and busy low.
//   command 0 binds texture_tag for model_id: a hit adds the model to the lowest
//   matching slot's referrers, a miss claims the lowest free slot. command 1 drops
//   model_id from every slot and frees slots left without referrers.
//   Result channel: done is high for exactly one cycle with slot_index, hit,
//   exhausted, first_owner and used_count; the receiver cannot hold it off, and
//   the block needs no back-pressure since only one item is in flight.
//   Flow: an item runs from the accepting edge through the scan and the finish step
//   to the done cycle; a new item may be started in the done cycle, and not before.
//   The scan goes through the entry memory one entry per cycle over its single read
//   port, with registered read data, and is followed by the final write-back.
//   An out-of-range model id skips the scan and goes straight to the finish step.
//   Reset: rst_n clears all valid flags and the used count at once; the entry memory
//   is not cleared, as only valid entries are ever looked at. No clearing pass.
module shared_texture_slot_table_unit #(
    parameter int unsigned SLOTS    = stst_pkg::SLOTS_DEFAULT,
    parameter int unsigned MODELS   = stst_pkg::MODELS_DEFAULT,
    parameter int unsigned TAG_BITS = stst_pkg::TAG_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              command,
    input  logic [stst_pkg::TAG_W-1:0]        texture_tag,
    input  logic [stst_pkg::MODEL_W-1:0]      model_id,
    output logic                              done,
    output logic [stst_pkg::IDX_OUT_W-1:0]    slot_index,
    output logic                              hit,
    output logic                              exhausted,
    output logic [stst_pkg::MODEL_W-1:0]      first_owner,
    output logic [stst_pkg::COUNT_OUT_W-1:0]  used_count
);

    localparam int unsigned IDXW    = $clog2(SLOTS);
    localparam int unsigned CNTW    = $clog2(SLOTS + 1);
    localparam int unsigned MW      = stst_pkg::MODEL_W;
    localparam int unsigned ENTRY_W = TAG_BITS + MW + MODELS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

    logic [1:0]          state_reg, state_next;
    logic                cmd_reg, cmd_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [MW-1:0]       model_reg, model_next;
    logic                skip_reg, skip_next;

    logic [IDXW-1:0]     scan_addr_reg, scan_addr_next;
    logic                issue_reg, issue_next;
    logic                proc_vld_reg, proc_vld_next;
    logic [IDXW-1:0]     proc_idx_reg, proc_idx_next;

    logic                found_reg, found_next;
    logic [IDXW-1:0]     found_idx_reg, found_idx_next;
    logic [MW-1:0]       found_owner_reg, found_owner_next;
    logic [MODELS-1:0]   found_refs_reg, found_refs_next;
    logic                free_found_reg, free_found_next;
    logic [IDXW-1:0]     free_idx_reg, free_idx_next;

    logic                              done_reg, done_next;
    logic [stst_pkg::IDX_OUT_W-1:0]    res_slot_reg, res_slot_next;
    logic                              res_hit_reg, res_hit_next;
    logic                              res_exh_reg, res_exh_next;
    logic [MW-1:0]                     res_owner_reg, res_owner_next;
    logic [stst_pkg::COUNT_OUT_W-1:0]  res_count_reg, res_count_next;

    // Memory and tracker hookup
    logic                mem_wr_en;
    logic [IDXW-1:0]     mem_wr_addr;
    logic [ENTRY_W-1:0]  mem_wr_data;
    logic                mem_rd_en;
    logic [ENTRY_W-1:0]  mem_rd_data;

    stst_pkg::stst_vop_t vop;
    logic [IDXW-1:0]     vop_idx;
    logic                cur_valid;
    logic [CNTW-1:0]     count;

    logic [TAG_BITS-1:0] rd_tag;
    logic [MW-1:0]       rd_owner;
    logic [MODELS-1:0]   rd_refs;
    logic [MODELS-1:0]   model_mask;
    logic [MODELS-1:0]   kept_refs;
    logic                model_ok;

    assign rd_tag     = mem_rd_data[ENTRY_W-1 -: TAG_BITS];
    assign rd_owner   = mem_rd_data[MODELS +: MW];
    assign rd_refs    = mem_rd_data[MODELS-1:0];
    assign model_mask = MODELS'(1) << model_reg;
    assign kept_refs  = rd_refs & ~model_mask;
    assign model_ok   = 32'(model_id) < MODELS;

    stst_slot_mem #(
        .DEPTH (SLOTS),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (scan_addr_reg),
        .rd_data (mem_rd_data)
    );

    stst_valid_bits #(
        .SLOTS (SLOTS)
    ) u_valid (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (vop),
        .op_idx   (vop_idx),
        .rd_idx   (proc_idx_reg),
        .rd_valid (cur_valid),
        .count    (count)
    );

    // Scan reads entry i while entry i-1 is written back, so read and write never
    // meet on one entry; the bind write lands after the scan has finished.
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        tag_next         = tag_reg;
        model_next       = model_reg;
        skip_next        = skip_reg;
        scan_addr_next   = scan_addr_reg;
        issue_next       = issue_reg;
        proc_vld_next    = 1'b0;
        proc_idx_next    = proc_idx_reg;
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        found_owner_next = found_owner_reg;
        found_refs_next  = found_refs_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        done_next        = 1'b0;
        res_slot_next    = res_slot_reg;
        res_hit_next     = res_hit_reg;
        res_exh_next     = res_exh_reg;
        res_owner_next   = res_owner_reg;
        res_count_next   = res_count_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = proc_idx_reg;
        mem_wr_data      = {rd_tag, rd_owner, kept_refs};
        mem_rd_en        = 1'b0;
        vop              = '0;
        vop_idx          = proc_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next        = command;
                    tag_next        = texture_tag[TAG_BITS-1:0];
                    model_next      = model_id;
                    skip_next       = !model_ok;
                    scan_addr_next  = '0;
                    issue_next      = 1'b1;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = model_ok ? ST_SCAN : ST_FINISH;
                end
            end

            ST_SCAN:
            begin
                if (issue_reg)
                begin
                    mem_rd_en     = 1'b1;
                    proc_vld_next = 1'b1;
                    proc_idx_next = scan_addr_reg;
                    if (scan_addr_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_addr_next = scan_addr_reg + IDXW'(1);
                    end
                end
                if (proc_vld_reg)
                begin
                    if (cmd_reg == stst_pkg::CMD_BIND)
                    begin
                        // Keep the lowest match and the lowest free slot
                        if (cur_valid && rd_tag == tag_reg && !found_reg)
                        begin
                            found_next       = 1'b1;
                            found_idx_next   = proc_idx_reg;
                            found_owner_next = rd_owner;
                            found_refs_next  = rd_refs;
                        end
                        if (!cur_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = proc_idx_reg;
                        end
                    end
                    else if (cur_valid)
                    begin
                        mem_wr_en  = 1'b1;
                        vop.clr_en = (kept_refs == '0);
                    end
                    if (proc_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                done_next      = 1'b1;
                state_next     = ST_IDLE;
                res_slot_next  = '0;
                res_hit_next   = 1'b0;
                res_exh_next   = 1'b0;
                res_owner_next = '0;
                res_count_next = stst_pkg::COUNT_OUT_W'(count);
                if (!skip_reg && cmd_reg == stst_pkg::CMD_BIND)
                begin
                    if (found_reg)
                    begin
                        mem_wr_en      = 1'b1;
                        mem_wr_addr    = found_idx_reg;
                        mem_wr_data    = {tag_reg, found_owner_reg, found_refs_reg | model_mask};
                        res_slot_next  = stst_pkg::IDX_OUT_W'(found_idx_reg);
                        res_hit_next   = 1'b1;
                        res_owner_next = found_owner_reg;
                    end
                    else if (free_found_reg)
                    begin
                        mem_wr_en      = 1'b1;
                        mem_wr_addr    = free_idx_reg;
                        mem_wr_data    = {tag_reg, model_reg, model_mask};
                        vop.set_en     = 1'b1;
                        vop_idx        = free_idx_reg;
                        res_slot_next  = stst_pkg::IDX_OUT_W'(free_idx_reg);
                        res_owner_next = model_reg;
                        res_count_next = stst_pkg::COUNT_OUT_W'(count + CNTW'(1));
                    end
                    else
                    begin
                        res_exh_next = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            issue_reg    <= 1'b0;
            proc_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            issue_reg    <= issue_next;
            proc_vld_reg <= proc_vld_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        tag_reg         <= tag_next;
        model_reg       <= model_next;
        skip_reg        <= skip_next;
        scan_addr_reg   <= scan_addr_next;
        proc_idx_reg    <= proc_idx_next;
        found_reg       <= found_next;
        found_idx_reg   <= found_idx_next;
        found_owner_reg <= found_owner_next;
        found_refs_reg  <= found_refs_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        res_slot_reg    <= res_slot_next;
        res_hit_reg     <= res_hit_next;
        res_exh_reg     <= res_exh_next;
        res_owner_reg   <= res_owner_next;
        res_count_reg   <= res_count_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign slot_index  = res_slot_reg;
    assign hit         = res_hit_reg;
    assign exhausted   = res_exh_reg;
    assign first_owner = res_owner_reg;
    assign used_count  = res_count_reg;

endmodule

### hw/rtl/stst_slot_mem.sv
// Single-port-write, single-port-read slot entry memory with registered read data.
// Depends on nothing; instantiated by shared_texture_slot_table_unit.
module stst_slot_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 84
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/stst_valid_bits.sv
// Per-slot valid flags and the running count of used slots.
// Depends on stst_pkg (stst_vop_t); instantiated by shared_texture_slot_table_unit.
module stst_valid_bits #(
    parameter int unsigned SLOTS = stst_pkg::SLOTS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  stst_pkg::stst_vop_t            op,
    input  logic [$clog2(SLOTS)-1:0]       op_idx,
    input  logic [$clog2(SLOTS)-1:0]       rd_idx,
    output logic                           rd_valid,
    output logic [$clog2(SLOTS+1)-1:0]     count
);

    localparam int unsigned CNTW = $clog2(SLOTS + 1);

    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;
    logic [CNTW-1:0]  count_reg;
    logic [CNTW-1:0]  count_next;

    // Callers set only a free slot and clear only a used one, so the count tracks the flags.
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (op.set_en)
        begin
            valid_next[op_idx] = 1'b1;
            count_next         = count_reg + CNTW'(1);
        end
        else if (op.clr_en)
        begin
            valid_next[op_idx] = 1'b0;
            count_next         = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    assign rd_valid = valid_reg[rd_idx];
    assign count    = count_reg;

endmodule

### hw/rtl/stst_checker.sv
// Port-level checks for the texture slot table, with the bind that attaches them.
// Depends on stst_pkg and on shared_texture_slot_table_unit being compiled first.
module stst_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [stst_pkg::IDX_OUT_W-1:0]    slot_index,
    input logic                              hit,
    input logic                              exhausted,
    input logic [stst_pkg::MODEL_W-1:0]      first_owner
);

    // Drop into the work the cycle after a beat is taken
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted beat");

    // One item in flight: results never come on consecutive cycles
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> !exhausted)
        else $error("hit and exhausted together");

    a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && exhausted |-> slot_index == '0 && first_owner == '0)
        else $error("exhausted result carries a slot or owner");

endmodule

bind shared_texture_slot_table_unit stst_checker u_stst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .slot_index  (slot_index),
    .hit         (hit),
    .exhausted   (exhausted),
    .first_owner (first_owner)
);
